### rtl/rvt_pkg.sv
// ----------------------------------------------------------------------------
// rvt_pkg: shared types, constants and functions for the vertex rotator
// Holds the angle arithmetic, the quadrant folding of the sine table and
// the elaboration-time generator of the first-quadrant sine values.
// ----------------------------------------------------------------------------
`default_nettype none

package rvt_pkg;

   localparam int unsigned COORD_WIDTH_DEF = 24;
   localparam int unsigned TRIG_FRAC_DEF   = 14;

   localparam int unsigned ANGLE_WIDTH  = 10;
   localparam int unsigned DEG_WIDTH    = 9;
   localparam int unsigned IDX_WIDTH    = 7;
   localparam int unsigned FULL_TURN    = 360;
   localparam int unsigned HALF_TURN    = 180;
   localparam int unsigned QUARTER_TURN = 90;
   localparam longint unsigned PI_Q30   = 64'd3373259426;

   // Index into the first-quadrant table plus the sign to apply.
   typedef struct packed {
      logic [IDX_WIDTH-1:0] idx;
      logic                 neg;
   } rvt_tab_sel_type;

   // Fold a signed angle register value into 0..359 degrees.
   function automatic logic [DEG_WIDTH-1:0] reduce_angle(
      input logic signed [ANGLE_WIDTH-1:0] ang);
      logic signed [ANGLE_WIDTH:0] wide;
      logic signed [ANGLE_WIDTH:0] turn;
      logic signed [ANGLE_WIDTH:0] res;
      wide = {ang[ANGLE_WIDTH-1], ang};
      turn = (ANGLE_WIDTH+1)'(FULL_TURN);
      if (wide >= turn) begin
         res = wide - turn;
      end else if (wide >= 0) begin
         res = wide;
      end else if (wide >= -turn) begin
         res = wide + turn;
      end else begin
         res = wide + turn + turn;
      end
      return res[DEG_WIDTH-1:0];
   endfunction

   // Cosine is the sine of the angle advanced by a quarter turn.
   function automatic logic [DEG_WIDTH-1:0] cos_angle(input logic [DEG_WIDTH-1:0] a);
      logic [DEG_WIDTH-1:0] res;
      if (a >= DEG_WIDTH'(FULL_TURN - QUARTER_TURN)) begin
         res = a - DEG_WIDTH'(FULL_TURN - QUARTER_TURN);
      end else begin
         res = a + DEG_WIDTH'(QUARTER_TURN);
      end
      return res;
   endfunction

   // Map an angle in 0..359 onto the first quadrant.
   function automatic rvt_tab_sel_type quad_sel(input logic [DEG_WIDTH-1:0] a);
      rvt_tab_sel_type sel;
      if (a <= DEG_WIDTH'(QUARTER_TURN)) begin
         sel.idx = a[IDX_WIDTH-1:0];
         sel.neg = 1'b0;
      end else if (a <= DEG_WIDTH'(HALF_TURN)) begin
         sel.idx = IDX_WIDTH'(DEG_WIDTH'(HALF_TURN) - a);
         sel.neg = 1'b0;
      end else if (a <= DEG_WIDTH'(HALF_TURN + QUARTER_TURN)) begin
         sel.idx = IDX_WIDTH'(a - DEG_WIDTH'(HALF_TURN));
         sel.neg = 1'b1;
      end else begin
         sel.idx = IDX_WIDTH'(DEG_WIDTH'(FULL_TURN) - a);
         sel.neg = 1'b1;
      end
      return sel;
   endfunction

   // Unsigned shift-and-subtract quotient, used only while building the
   // constant sine table.
   function automatic longint unsigned div_u64(input longint unsigned num,
                                               input longint unsigned den);
      longint unsigned quo;
      longint unsigned rem;
      quo = '0;
      rem = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], num[i]};
         if (rem >= den) begin
            rem    = rem - den;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // sin(k degrees) in Q.30 by an integer Taylor series, rounded half up
   // to frac_bits. Only ever called with constant arguments.
   function automatic longint unsigned quad_sin_val(input int unsigned k,
                                                    input int unsigned frac_bits);
      longint unsigned x;
      longint unsigned x2;
      longint unsigned term;
      longint unsigned sum;
      longint unsigned half;
      longint unsigned den;
      int unsigned     n;
      bit              sub;
      x    = div_u64(longint'(k) * PI_Q30 + 64'(QUARTER_TURN), 64'(HALF_TURN));
      x2   = (x * x) >> 30;
      term = x;
      sum  = x;
      n    = 1;
      sub  = 1'b1;
      while (term != 0 && n < 40) begin
         den  = 64'((n + 1) * (n + 2));
         term = div_u64((term * x2) >> 30, den);
         n    = n + 2;
         if (sub) begin
            sum = sum - term;
         end else begin
            sum = sum + term;
         end
         sub = !sub;
      end
      half = 64'd1 << (29 - frac_bits);
      return (sum + half) >> (30 - frac_bits);
   endfunction

endpackage

`default_nettype wire

### rtl/rvt_if.sv
// ----------------------------------------------------------------------------
// rvt_if: channel interfaces of the vertex rotator
// Vertex request, rotated vertex response and angle register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface rvt_req_if import rvt_pkg::*; #(
   parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] x;
   logic signed [COORD_WIDTH-1:0] y;
   logic                          last_vertex;

   modport source (output valid, x, y, last_vertex, input ready);
   modport sink   (input valid, x, y, last_vertex, output ready);
endinterface

interface rvt_rsp_if import rvt_pkg::*; #(
   parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] rx;
   logic signed [COORD_WIDTH-1:0] ry;
   logic                          last_out;

   modport source (output valid, rx, ry, last_out, input ready);
   modport sink   (input valid, rx, ry, last_out, output ready);
endinterface

interface rvt_csr_if import rvt_pkg::*; ();
   logic                          valid;
   logic                          ready;
   logic signed [ANGLE_WIDTH-1:0] angle_deg;

   modport source (output valid, angle_deg, input ready);
   modport sink   (input valid, angle_deg, output ready);
endinterface

`default_nettype wire

### rtl/rvt_angle.sv
// ----------------------------------------------------------------------------
// rvt_angle: angle register and sine/cosine lookup
// Stores the reduced angle and registers its sine and cosine from the table.
// ----------------------------------------------------------------------------
`default_nettype none

module rvt_angle import rvt_pkg::*; #(
   parameter int unsigned TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic signed [ANGLE_WIDTH-1:0]   csr_angle_deg,
   output logic signed [TRIG_FRAC_BITS+1:0]     sin_val,
   output logic signed [TRIG_FRAC_BITS+1:0]     cos_val
);

   localparam int unsigned SIN_W = TRIG_FRAC_BITS + 2;

   logic [TRIG_FRAC_BITS:0]   quad_tab [0:QUARTER_TURN];
   logic [DEG_WIDTH-1:0]      ang_ff;
   logic [DEG_WIDTH-1:0]      ang_in;
   rvt_tab_sel_type           sel_sin;
   rvt_tab_sel_type           sel_cos;
   logic signed [SIN_W-1:0]   sin_in;
   logic signed [SIN_W-1:0]   cos_in;
   logic signed [SIN_W-1:0]   sin_ff;
   logic signed [SIN_W-1:0]   cos_ff;
   logic signed [SIN_W-1:0]   sin_mag;
   logic signed [SIN_W-1:0]   cos_mag;

   // First-quadrant sine values, fixed at elaboration.
   for (genvar k = 0; k <= QUARTER_TURN; k++) begin : g_tab
      assign quad_tab[k] = (TRIG_FRAC_BITS+1)'(quad_sin_val(k, TRIG_FRAC_BITS));
   end

   assign csr_ready = 1'b1;

   always_comb begin
      ang_in = ang_ff;
      if (csr_valid) begin
         ang_in = reduce_angle(csr_angle_deg);
      end
   end

   always_comb begin
      sel_sin = quad_sel(ang_ff);
      sel_cos = quad_sel(cos_angle(ang_ff));
      sin_mag = $signed({1'b0, quad_tab[sel_sin.idx]});
      cos_mag = $signed({1'b0, quad_tab[sel_cos.idx]});
      sin_in  = sel_sin.neg ? -sin_mag : sin_mag;
      cos_in  = sel_cos.neg ? -cos_mag : cos_mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ang_ff <= '0;
      end else begin
         ang_ff <= ang_in;
      end
   end

   always_ff @(posedge clock) begin
      sin_ff <= sin_in;
      cos_ff <= cos_in;
   end

   assign sin_val = sin_ff;
   assign cos_val = cos_ff;

endmodule

`default_nettype wire

### rtl/rvt_rotate.sv
// ----------------------------------------------------------------------------
// rvt_rotate: four-stage rotation pipeline
// Capture, multiply, add, then round and saturate into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rvt_rotate import rvt_pkg::*; #(
   parameter int unsigned COORD_WIDTH    = COORD_WIDTH_DEF,
   parameter int unsigned TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_ready,
   input  wire logic signed [COORD_WIDTH-1:0]     req_x,
   input  wire logic signed [COORD_WIDTH-1:0]     req_y,
   input  wire logic                              req_last_vertex,
   input  wire logic signed [TRIG_FRAC_BITS+1:0]  sin_val,
   input  wire logic signed [TRIG_FRAC_BITS+1:0]  cos_val,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_ready,
   output logic signed [COORD_WIDTH-1:0]          rsp_rx,
   output logic signed [COORD_WIDTH-1:0]          rsp_ry,
   output logic                                   rsp_last_out
);

   localparam int unsigned SIN_W = TRIG_FRAC_BITS + 2;
   localparam int unsigned PW    = COORD_WIDTH + SIN_W;
   localparam int unsigned SW    = PW + 1;
   localparam int unsigned QW    = SW - TRIG_FRAC_BITS;
   localparam logic signed [SW-1:0] RND   = SW'(64'd1 << (TRIG_FRAC_BITS - 1));
   localparam logic signed [QW-1:0] Q_MAX = QW'((64'd1 << (COORD_WIDTH - 1)) - 64'd1);
   localparam logic signed [QW-1:0] Q_MIN = -Q_MAX - QW'(1);

   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic rdy1, rdy2, rdy3, rdy4;

   logic signed [COORD_WIDTH-1:0] x1_ff, y1_ff;
   logic                          l1_ff, l2_ff, l3_ff, l4_ff;
   logic signed [PW-1:0]          xc_ff, ys_ff, xs_ff, yc_ff;
   logic signed [PW-1:0]          xc_in, ys_in, xs_in, yc_in;
   logic signed [SW-1:0]          px_ff, py_ff;
   logic signed [SW-1:0]          px_in, py_in;
   logic signed [SW-1:0]          bx, by;
   logic signed [QW-1:0]          qx, qy;
   logic signed [COORD_WIDTH-1:0] rx_in, ry_in, rx_ff, ry_ff;

   // A stage takes a new item when it is empty or its successor moves.
   assign rdy4      = !v4_ff || rsp_ready;
   assign rdy3      = !v3_ff || rdy4;
   assign rdy2      = !v2_ff || rdy3;
   assign rdy1      = !v1_ff || rdy2;
   assign req_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff;
         if (rdy4) v4_ff <= v3_ff;
      end
   end

   always_comb begin
      xc_in = PW'(x1_ff) * PW'(cos_val);
      ys_in = PW'(y1_ff) * PW'(sin_val);
      xs_in = PW'(x1_ff) * PW'(sin_val);
      yc_in = PW'(y1_ff) * PW'(cos_val);
   end

   always_comb begin
      px_in = SW'(xc_ff) - SW'(ys_ff);
      py_in = SW'(xs_ff) + SW'(yc_ff);
   end

   // Round half up, floor shift, then clamp to the coordinate range.
   always_comb begin
      bx = px_ff + RND;
      by = py_ff + RND;
      qx = $signed(bx[SW-1:TRIG_FRAC_BITS]);
      qy = $signed(by[SW-1:TRIG_FRAC_BITS]);
      if (qx > Q_MAX) begin
         rx_in = Q_MAX[COORD_WIDTH-1:0];
      end else if (qx < Q_MIN) begin
         rx_in = Q_MIN[COORD_WIDTH-1:0];
      end else begin
         rx_in = qx[COORD_WIDTH-1:0];
      end
      if (qy > Q_MAX) begin
         ry_in = Q_MAX[COORD_WIDTH-1:0];
      end else if (qy < Q_MIN) begin
         ry_in = Q_MIN[COORD_WIDTH-1:0];
      end else begin
         ry_in = qy[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && rdy1) begin
         x1_ff <= req_x;
         y1_ff <= req_y;
         l1_ff <= req_last_vertex;
      end
      if (v1_ff && rdy2) begin
         xc_ff <= xc_in;
         ys_ff <= ys_in;
         xs_ff <= xs_in;
         yc_ff <= yc_in;
         l2_ff <= l1_ff;
      end
      if (v2_ff && rdy3) begin
         px_ff <= px_in;
         py_ff <= py_in;
         l3_ff <= l2_ff;
      end
      if (v3_ff && rdy4) begin
         rx_ff <= rx_in;
         ry_ff <= ry_in;
         l4_ff <= l3_ff;
      end
   end

   assign rsp_valid    = v4_ff;
   assign rsp_rx       = rx_ff;
   assign rsp_ry       = ry_ff;
   assign rsp_last_out = l4_ff;

endmodule

`default_nettype wire

### rtl/vertex_rotate_degree_table.sv
// An accepted vertex item passes the capture, product, sum and output registers to rsp.
// Throughput: one item per cycle while rsp is ready; a full stage holds while the next cannot move.
// The critical path is one coordinate-by-sine multiply in the second stage.
// Reset clears all pipeline valid bits and sets the angle to zero degrees.
// ----------------------------------------------------------------------------
// vertex_rotate_degree_table: 2D vertex rotation by a whole-degree angle
// Rotates a stream of Q16.8 vertices about the origin with table sine/cosine.
// ----------------------------------------------------------------------------
`default_nettype none

module vertex_rotate_degree_table import rvt_pkg::*; #(
   parameter int unsigned COORD_WIDTH    = COORD_WIDTH_DEF,
   parameter int unsigned TRIG_FRAC_BITS = TRIG_FRAC_DEF
) (
   input  wire logic  clock,
   input  wire logic  reset,
   rvt_req_if.sink    req_ch,
   rvt_rsp_if.source  rsp_ch,
   rvt_csr_if.sink    csr_ch
);

   // Sine and cosine of the current angle, in signed Q1.TRIG_FRAC_BITS.
   // They are registered behind the angle register, so a write reaches
   // them through both registers. An item accepted right after a write is
   // held in the capture register first, so it always sees the new angle.
   logic signed [TRIG_FRAC_BITS+1:0] sin_val;
   logic signed [TRIG_FRAC_BITS+1:0] cos_val;

   // The angle unit reduces any written angle into 0..359 degrees, folds it
   // onto the first-quadrant table and keeps the signed results in flops.
   rvt_angle #(
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_angle (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_ch.valid),
      .csr_ready     (csr_ch.ready),
      .csr_angle_deg (csr_ch.angle_deg),
      .sin_val       (sin_val),
      .cos_val       (cos_val)
   );

   // The rotation pipeline: capture the vertex, form the four products,
   // combine them, then round to nearest and saturate in the output register.
   // The last-vertex flag rides along with each item unchanged.
   rvt_rotate #(
      .COORD_WIDTH    (COORD_WIDTH),
      .TRIG_FRAC_BITS (TRIG_FRAC_BITS)
   ) u_rotate (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_ch.valid),
      .req_ready       (req_ch.ready),
      .req_x           (req_ch.x),
      .req_y           (req_ch.y),
      .req_last_vertex (req_ch.last_vertex),
      .sin_val         (sin_val),
      .cos_val         (cos_val),
      .rsp_valid       (rsp_ch.valid),
      .rsp_ready       (rsp_ch.ready),
      .rsp_rx          (rsp_ch.rx),
      .rsp_ry          (rsp_ch.ry),
      .rsp_last_out    (rsp_ch.last_out)
   );

endmodule

`default_nettype wire

### rtl/rvt_checker.sv
// ----------------------------------------------------------------------------
// rvt_checker: port-level assertions for the vertex rotator
// Checks response handshake behavior, reset emptiness and pipeline latency.
// ----------------------------------------------------------------------------
`default_nettype none

module rvt_checker import rvt_pkg::*; #(
   parameter int unsigned COORD_WIDTH = COORD_WIDTH_DEF
) (
   input wire logic                          clock,
   input wire logic                          reset,
   input wire logic                          req_valid,
   input wire logic                          req_ready,
   input wire logic                          req_last_vertex,
   input wire logic                          rsp_valid,
   input wire logic                          rsp_ready,
   input wire logic signed [COORD_WIDTH-1:0] rsp_rx,
   input wire logic signed [COORD_WIDTH-1:0] rsp_ry,
   input wire logic                          rsp_last_out
);

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response item dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=>
         $stable(rsp_rx) && $stable(rsp_ry) && $stable(rsp_last_out))
      else $error("stalled response item changed");

   a_empty_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // With rsp ready while an accepted item moves down the stages, it reaches rsp with its flag.
   a_latency_flag: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready ##1 rsp_ready ##1 rsp_ready ##1 rsp_ready |=>
         rsp_valid && rsp_last_out == $past(req_last_vertex, 4))
      else $error("item did not arrive after four cycles with its flag");

endmodule

bind vertex_rotate_degree_table rvt_checker #(
   .COORD_WIDTH (COORD_WIDTH)
) u_rvt_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .req_last_vertex (req_ch.last_vertex),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_rx          (rsp_ch.rx),
   .rsp_ry          (rsp_ch.ry),
   .rsp_last_out    (rsp_ch.last_out)
);

`default_nettype wire

### sim/vertex_rotate_checker.sv
// ----------------------------------------------------------------------------
// vertex_rotate_checker: prediction and result checking for the vertex rotator
// Watches the angle write, vertex and rotated vertex channels, rotates every
// accepted vertex with its own sine table and compares the results in order.
// ----------------------------------------------------------------------------
module vertex_rotate_checker import rvt_pkg::*; (
   input  logic clock,
   input  logic reset,
   rvt_req_if   req_ch,
   rvt_rsp_if   rsp_ch,
   rvt_csr_if   csr_ch,
   output int   mismatch_count,
   output int   results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CW   = COORD_WIDTH_DEF;
   localparam int FRAC = TRIG_FRAC_DEF;
   localparam longint unsigned PI_IN_Q30 = 64'd3373259426;

   typedef logic signed [CW-1:0] coord_t;
   typedef struct packed {
      coord_t rx;
      coord_t ry;
      logic   last_out;
   } rotated_vertex_t;

   longint                        quarter_sine [0:QUARTER_TURN];
   logic signed [ANGLE_WIDTH-1:0] angle_shadow;
   rotated_vertex_t               rotated_owed [$];

   // Sine of a whole degree in Q.30 from an integer Taylor series.
   function automatic longint unsigned sine_q30(input int unsigned deg);
      longint unsigned rad;
      longint unsigned rad_sq;
      longint unsigned term;
      longint unsigned acc;
      int unsigned     order;
      bit              negate;
      rad    = (64'(deg) * PI_IN_Q30 + 64'(HALF_TURN / 2)) / 64'(HALF_TURN);
      rad_sq = (rad * rad) >> 30;
      term   = rad;
      acc    = rad;
      order  = 1;
      negate = 1'b1;
      while (term != 0 && order < 40) begin
         term   = ((term * rad_sq) >> 30) / 64'((order + 1) * (order + 2));
         order  = order + 2;
         acc    = negate ? acc - term : acc + term;
         negate = !negate;
      end
      return acc;
   endfunction

   initial begin
      for (int k = 0; k <= int'(QUARTER_TURN); k++) begin
         quarter_sine[k] = longint'((sine_q30(k) + (64'd1 << (29 - FRAC))) >> (30 - FRAC));
      end
   end

   function automatic longint signed_sine(input int deg);
      if (deg <= int'(QUARTER_TURN)) return quarter_sine[deg];
      if (deg <= int'(HALF_TURN)) return quarter_sine[int'(HALF_TURN) - deg];
      if (deg <= int'(HALF_TURN + QUARTER_TURN)) return -quarter_sine[deg - int'(HALF_TURN)];
      return -quarter_sine[int'(FULL_TURN) - deg];
   endfunction

   // Round half up, then clamp to the coordinate range.
   function automatic coord_t round_saturate(input longint acc);
      longint q;
      longint hi;
      longint lo;
      q  = (acc + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      hi = (longint'(1) <<< (CW - 1)) - 1;
      lo = -hi - 1;
      if (q > hi) q = hi;
      else if (q < lo) q = lo;
      return coord_t'(q);
   endfunction

   function automatic rotated_vertex_t rotate_vertex(input logic signed [ANGLE_WIDTH-1:0] ang,
                                                     input coord_t x, input coord_t y,
                                                     input logic last);
      int              deg;
      longint          s;
      longint          c;
      rotated_vertex_t r;
      deg = int'(ang) % int'(FULL_TURN);
      if (deg < 0) deg = deg + int'(FULL_TURN);
      s = signed_sine(deg);
      c = signed_sine((deg + int'(QUARTER_TURN)) % int'(FULL_TURN));
      r.rx       = round_saturate(longint'(x) * c - longint'(y) * s);
      r.ry       = round_saturate(longint'(x) * s + longint'(y) * c);
      r.last_out = last;
      return r;
   endfunction

   always @(posedge clock) begin
      rotated_vertex_t owed;
      if (reset) begin
         angle_shadow = '0;
         rotated_owed.delete();
         mismatch_count = 0;
         results_owed   = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) begin
            angle_shadow = csr_ch.angle_deg;
         end
         // Results are checked before new vertices are queued so that an
         // unexpected item is never matched with one accepted at this edge.
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (rotated_owed.size() == 0) begin
               $error("unexpected rotated item: rx %0d, ry %0d, last_out %0b",
                      rsp_ch.rx, rsp_ch.ry, rsp_ch.last_out);
               mismatch_count++;
            end else begin
               owed = rotated_owed.pop_front();
               if (rsp_ch.rx !== owed.rx) begin
                  $error("rx mismatch: expected %0d, actual %0d", owed.rx, rsp_ch.rx);
                  mismatch_count++;
               end
               if (rsp_ch.ry !== owed.ry) begin
                  $error("ry mismatch: expected %0d, actual %0d", owed.ry, rsp_ch.ry);
                  mismatch_count++;
               end
               if (rsp_ch.last_out !== owed.last_out) begin
                  $error("last_out mismatch: expected %0b, actual %0b",
                         owed.last_out, rsp_ch.last_out);
                  mismatch_count++;
               end
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            rotated_owed.push_back(rotate_vertex(angle_shadow, req_ch.x, req_ch.y,
                                                 req_ch.last_vertex));
         end
         results_owed = rotated_owed.size();
      end
   end

endmodule

### sim/vertex_rotate_degree_table_tb.sv
// ----------------------------------------------------------------------------
// vertex_rotate_degree_table_tb: testbench top for the vertex rotator
// Drives corner vertices and random polygon streams through a series of
// rotation angles, with random gaps and back pressure, and reports a verdict.
// ----------------------------------------------------------------------------
module vertex_rotate_degree_table_tb import rvt_pkg::*; ;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int COORD_W       = COORD_WIDTH_DEF;
   localparam real CLK_PERIOD   = 10.0;
   localparam int RANDOM_PHASES = 15;
   // The pipeline is four stages deep; the settle wait leaves margin beyond that.
   localparam int SETTLE_CYCLES = 8;
   // Worst case per item is a long sender gap plus a long receiver stall;
   // this limit covers every item at that pace many times.
   localparam int unsigned CYCLE_LIMIT = 400000;

   typedef logic signed [COORD_W-1:0] coord_t;

   localparam coord_t COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
   localparam coord_t COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

   // Angles for the first random phases: both ends of the register, the
   // ends of the documented range, the quadrant boundaries and values next
   // to zero. Later phases pick the angle at random over all ten bits.
   localparam int ANGLE_PLAN [12] = '{-512, 511, -360, 360, 90, 180, 270, -90,
                                      1, -1, 359, 0};

   logic clock = 1'b0;
   logic reset;
   int   mismatch_count;
   int   results_owed;

   rvt_req_if #(.COORD_WIDTH(COORD_W)) req_ch ();
   rvt_rsp_if #(.COORD_WIDTH(COORD_W)) rsp_ch ();
   rvt_csr_if                          csr_ch ();

   vertex_rotate_degree_table #(
      .COORD_WIDTH    (COORD_W),
      .TRIG_FRAC_BITS (TRIG_FRAC_DEF)
   ) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   // The checker sees the same channels as the block and keeps the
   // expected results; the top only reads its counters.
   vertex_rotate_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_ch),
      .rsp_ch         (rsp_ch),
      .csr_ch         (csr_ch),
      .mismatch_count (mismatch_count),
      .results_owed   (results_owed)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // Mostly back-to-back items, some short gaps and now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // Coordinates: a tenth are extremes or values next to zero, three tenths are
   // modest values that rotate without clipping, and the rest cover the whole
   // range, which exercises saturation and toggles every bit.
   function automatic coord_t pick_coord();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0:       return COORD_MAX;
               1:       return COORD_MIN;
               2:       return '0;
               3:       return '1;
               default: return coord_t'(1);
            endcase
         end
         1, 2, 3: return coord_t'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
         default: return coord_t'($urandom());
      endcase
   endfunction

   // Presents one vertex, optionally after an idle gap, and returns on the
   // falling edge after the item is taken. Valid is left high so that the
   // next vertex can follow without a bubble.
   task automatic send_vertex(input coord_t x, input coord_t y, input logic last,
                              input int gap);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.x           <= x;
      req_ch.y           <= y;
      req_ch.last_vertex <= last;
      do @(posedge clock); while (!req_ch.ready);
      @(negedge clock);
   endtask

   // Stops sending and waits until every rotated item has come back, plus a
   // settle wait so that the pipeline is certainly empty.
   task automatic drain_pipeline();
      req_ch.valid <= 1'b0;
      while (results_owed != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // Writes the angle register; only called while the block is idle.
   task automatic write_angle(input logic signed [ANGLE_WIDTH-1:0] angle);
      csr_ch.valid     <= 1'b1;
      csr_ch.angle_deg <= angle;
      do @(posedge clock); while (!csr_ch.ready);
      @(negedge clock);
      csr_ch.valid <= 1'b0;
   endtask

   // Corner vertices: the origin, each axis at both extremes, the four
   // diagonal extremes that clip at most angles, one unit and single-LSB
   // values that probe rounding.
   task automatic send_corner_vertices();
      send_vertex('0, '0, 1'b0, 0);
      send_vertex(COORD_MAX, '0, 1'b0, 0);
      send_vertex('0, COORD_MAX, 1'b0, 1);
      send_vertex(COORD_MIN, '0, 1'b0, 0);
      send_vertex('0, COORD_MIN, 1'b0, 0);
      send_vertex(COORD_MAX, COORD_MAX, 1'b0, 2);
      send_vertex(COORD_MIN, COORD_MIN, 1'b0, 0);
      send_vertex(COORD_MAX, COORD_MIN, 1'b0, 0);
      send_vertex(COORD_MIN, COORD_MAX, 1'b1, 0);
      send_vertex(coord_t'(256), '0, 1'b0, 3);
      send_vertex(coord_t'(1), '1, 1'b0, 0);
      send_vertex('1, coord_t'(1), 1'b1, 0);
   endtask

   // Receiver side: ready is mostly high with short stalls, occasional long
   // ones, and calm stretches during which it never drops.
   initial begin
      int stall_left;
      int calm_left;
      int roll;
      rsp_ch.ready = 1'b0;
      stall_left   = 0;
      calm_left    = 0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            stall_left--;
         end else if (calm_left > 0) begin
            calm_left--;
            rsp_ch.ready <= 1'b1;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 2) begin
               calm_left = $urandom_range(40, 200);
               rsp_ch.ready <= 1'b1;
            end else if (roll < 20) begin
               rsp_ch.ready <= 1'b0;
               stall_left = (roll < 18) ? $urandom_range(0, 2) : $urandom_range(8, 40);
            end else begin
               rsp_ch.ready <= 1'b1;
            end
         end
      end
   end

   // A hung block or a lost item ends the run here.
   initial begin
      int unsigned cycle_count;
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      logic signed [ANGLE_WIDTH-1:0] angle;
      int                            burst_len;
      int                            poly_left;
      logic                          last_flag;
      bit                            calm;

      req_ch.valid       = 1'b0;
      req_ch.x           = '0;
      req_ch.y           = '0;
      req_ch.last_vertex = 1'b0;
      csr_ch.valid       = 1'b0;
      csr_ch.angle_deg   = '0;
      reset              = 1'b1;
      poly_left          = 0;

      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // The first corner pass runs at the reset angle of zero degrees, the
      // second at 45 degrees, where both diagonals clip.
      send_corner_vertices();
      drain_pipeline();
      write_angle(ANGLE_WIDTH'(45));
      send_corner_vertices();
      drain_pipeline();

      // Random phases: each sets an angle while idle, then streams polygons
      // of one to eight vertices whose last vertex carries the flag. A tenth
      // of the flags are random so that broken polygons also appear.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         if (phase < 12) angle = ANGLE_WIDTH'(ANGLE_PLAN[phase]);
         else angle = ANGLE_WIDTH'($urandom_range(0, (1 << ANGLE_WIDTH) - 1));
         write_angle(angle);
         // Every fourth phase runs without sender gaps.
         calm      = (phase % 4 == 3);
         burst_len = $urandom_range(40, 60);
         for (int i = 0; i < burst_len; i++) begin
            if (poly_left == 0) poly_left = $urandom_range(1, 8);
            poly_left--;
            last_flag = (poly_left == 0);
            if ($urandom_range(0, 9) == 0) last_flag = $urandom_range(0, 1);
            send_vertex(pick_coord(), pick_coord(), last_flag, calm ? 0 : pick_gap());
            // The sender sometimes holds off until the pipeline has emptied,
            // and always does so once in the middle of the second phase.
            if ((phase == 1 && i == burst_len / 2) || $urandom_range(0, 99) == 0) begin
               drain_pipeline();
            end
         end
         drain_pipeline();
      end

      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
